// ===== rtl/core/ptik_pkg.sv =====
// Shared types, constants and helper functions for the two-link planar IK block.
package ptik_pkg;

	// Default values of the top-level parameters.
	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int STEPS_DEF      = 16;

	// Fixed field widths.
	localparam int XY_W      = 18;
	localparam int LEN_W     = 17;
	localparam int ANG16_W   = 16;
	localparam int CFG_W     = 17;
	localparam int IDX_W     = 3;
	localparam int NUM_W     = 37;
	localparam int MAG_W     = 36;
	localparam int CORD_W    = 46;
	localparam int TABLE_N   = 24;
	localparam int NORM_BIT  = 40;
	localparam int COST_W    = 18;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_UPPER_LEN  = 3'd0,
		REG_LOWER_LEN  = 3'd1,
		REG_SHLDR_MIN  = 3'd2,
		REG_SHLDR_MAX  = 3'd3,
		REG_ELBOW_MIN  = 3'd4,
		REG_ELBOW_MAX  = 3'd5
	} cfg_reg_t;

	// Command to the divide / square-root unit.
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} ds_cmd_t;

	typedef enum logic [1:0] {DS_IDLE, DS_DIV, DS_SQRT, DS_DONE} ds_state_t;

	typedef enum logic [1:0] {CR_IDLE, CR_NORM, CR_ITER, CR_DONE} cr_state_t;

	// Order of the five atan2 runs of one transaction.
	typedef enum logic [2:0] {
		RUN_BASE  = 3'd0,
		RUN_T2_UP = 3'd1,
		RUN_T2_DN = 3'd2,
		RUN_C1_UP = 3'd3,
		RUN_C1_DN = 3'd4
	} run_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_XX, ST_YY, ST_L1, ST_L2, ST_LL, ST_DEN, ST_CHK1, ST_CHK2,
		ST_DIV, ST_DIVW, ST_CM2, ST_SQ, ST_SQW, ST_P, ST_Q, ST_QR,
		ST_COR, ST_CORW, ST_SEL, ST_UNR
	} ik_state_t;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32.
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Clamp to the joint limits; crossed limits give the lower limit.
	function automatic logic signed [ANG16_W-1:0] clamp_angle(
		input logic signed [ANG16_W-1:0] v,
		input logic signed [ANG16_W-1:0] lo,
		input logic signed [ANG16_W-1:0] hi);
		logic signed [ANG16_W-1:0] r;
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

	// Absolute wrapped distance between two binary angles.
	function automatic logic [ANG16_W:0] wrap_dist(
		input logic [ANG16_W-1:0] a,
		input logic [ANG16_W-1:0] prev);
		logic [ANG16_W-1:0] d;
		logic signed [ANG16_W:0] e;
		d = a - prev;
		e = $signed({d[ANG16_W-1], d});
		if (e < 0) e = -e;
		return $unsigned(e);
	endfunction

endpackage

// ===== rtl/core/ptik_divsqrt.sv =====
// Radix-2 restoring divider and bit-serial integer square root sharing one sequencer.
module ptik_divsqrt #(
	parameter int FRAC_BITS = ptik_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ptik_pkg::ds_cmd_t                      cmd,
	input  logic [ptik_pkg::MAG_W+FRAC_BITS:0]     div_num,
	input  logic [ptik_pkg::MAG_W-1:0]             div_den,
	input  logic [2*FRAC_BITS:0]                   sqrt_arg,
	output logic                                   done,
	output logic [FRAC_BITS+1:0]                   quotient,
	output logic [FRAC_BITS:0]                     root
);

	localparam int QW  = FRAC_BITS + 2;
	localparam int VW  = 2 * FRAC_BITS + 1;
	localparam int CNW = $clog2(QW + 1);
	localparam int MW  = ptik_pkg::MAG_W;

	ptik_pkg::ds_state_t state_q, state_d;
	logic [CNW-1:0] cnt_q;
	logic [MW-1:0]  rem_q;
	logic [MW-1:0]  den_q;
	logic [QW-1:0]  nlow_q;
	logic [QW-1:0]  quo_q;
	logic [VW:0]    v_q;
	logic [VW:0]    r_q;
	logic [VW:0]    bit_q;

	logic [MW:0]    trial;
	logic           ge;
	logic [VW:0]    rb;

	// Trial subtraction for division and trial sum for the square root.
	always_comb begin
		trial = {rem_q, nlow_q[QW-1]};
		ge    = trial >= {1'b0, den_q};
		rb    = r_q + bit_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptik_pkg::DS_IDLE: begin
				if (cmd.start) state_d = cmd.sqrt_mode ? ptik_pkg::DS_SQRT : ptik_pkg::DS_DIV;
			end
			ptik_pkg::DS_DIV, ptik_pkg::DS_SQRT: begin
				if (cnt_q == CNW'(1)) state_d = ptik_pkg::DS_DONE;
			end
			ptik_pkg::DS_DONE: state_d = ptik_pkg::DS_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		done     = (state_q == ptik_pkg::DS_DONE);
		quotient = quo_q;
		root     = r_q[FRAC_BITS:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptik_pkg::DS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ptik_pkg::DS_IDLE && cmd.start) begin
				cnt_q <= cmd.sqrt_mode ? CNW'(FRAC_BITS + 1) : CNW'(QW);
			end else if (state_q == ptik_pkg::DS_DIV || state_q == ptik_pkg::DS_SQRT) begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	// Datapath: one quotient bit or one root bit per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ptik_pkg::DS_IDLE && cmd.start) begin
			rem_q  <= MW'(div_num >> QW);
			nlow_q <= div_num[QW-1:0];
			den_q  <= div_den;
			quo_q  <= '0;
			v_q    <= {1'b0, sqrt_arg};
			r_q    <= '0;
			bit_q  <= (VW+1)'(1) << (2 * FRAC_BITS);
		end else if (state_q == ptik_pkg::DS_DIV) begin
			rem_q  <= ge ? MW'(trial - {1'b0, den_q}) : MW'(trial);
			quo_q  <= {quo_q[QW-2:0], ge};
			nlow_q <= {nlow_q[QW-2:0], 1'b0};
		end else if (state_q == ptik_pkg::DS_SQRT) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== rtl/core/ptik_cordic.sv =====
// Vectoring CORDIC atan2 with operand normalization, one rotation per cycle.
module ptik_cordic #(
	parameter int ANGLE_BITS = ptik_pkg::ANGLE_BITS_DEF,
	parameter int STEPS      = ptik_pkg::STEPS_DEF,
	parameter int IW         = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [IW-1:0]  y_in,
	input  logic signed [IW-1:0]  x_in,
	output logic                  done,
	output logic [ANGLE_BITS-1:0] angle
);

	localparam int CW    = ptik_pkg::CORD_W;
	localparam int NSTEP = (STEPS > ptik_pkg::TABLE_N) ? ptik_pkg::TABLE_N : STEPS;
	localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [31:0] TRND = 32'd1 << (31 - ANGLE_BITS);

	ptik_pkg::cr_state_t state_q, state_d;
	logic signed [CW-1:0]  x_q, y_q;
	logic [CW-1:0]         m_q;
	logic [ANGLE_BITS-1:0] ang_q;
	logic [4:0]            i_q;

	logic signed [CW-1:0]  xw, yw, ax, ay;
	logic                  special;
	logic signed [CW-1:0]  dx, dy;
	logic [31:0]           tfull;
	logic [ANGLE_BITS-1:0] t;

	// Operand preparation and one rotation step.
	always_comb begin
		xw      = CW'(x_in);
		yw      = CW'(y_in);
		ax      = (xw < 0) ? -xw : xw;
		ay      = (yw < 0) ? -yw : yw;
		special = (y_in == '0) || (x_in == '0);
		dx      = y_q >>> i_q;
		dy      = x_q >>> i_q;
		tfull   = (ptik_pkg::atan_turn(i_q) + TRND) >> (32 - ANGLE_BITS);
		t       = tfull[ANGLE_BITS-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptik_pkg::CR_IDLE: begin
				if (start) state_d = special ? ptik_pkg::CR_DONE : ptik_pkg::CR_NORM;
			end
			ptik_pkg::CR_NORM: begin
				if (m_q[CW-1:ptik_pkg::NORM_BIT] != '0) state_d = ptik_pkg::CR_ITER;
			end
			ptik_pkg::CR_ITER: begin
				if (i_q == 5'(NSTEP - 1)) state_d = ptik_pkg::CR_DONE;
			end
			ptik_pkg::CR_DONE: state_d = ptik_pkg::CR_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		done  = (state_q == ptik_pkg::CR_DONE);
		angle = ang_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptik_pkg::CR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (state_q == ptik_pkg::CR_IDLE && start) begin
			i_q <= '0;
			m_q <= (ax > ay) ? $unsigned(ax) : $unsigned(ay);
			if (y_in == '0) begin
				ang_q <= x_in[IW-1] ? HALF : '0;
			end else if (x_in == '0) begin
				ang_q <= y_in[IW-1] ? (ANGLE_BITS'(0) - QUARTER) : QUARTER;
			end else if (x_in[IW-1]) begin
				x_q   <= -xw;
				y_q   <= -yw;
				ang_q <= HALF;
			end else begin
				x_q   <= xw;
				y_q   <= yw;
				ang_q <= '0;
			end
		end else if (state_q == ptik_pkg::CR_NORM) begin
			// Scale up by powers of two until the larger magnitude reaches 2^40.
			if (m_q[CW-1:ptik_pkg::NORM_BIT-8] == '0) begin
				x_q <= x_q <<< 8;
				y_q <= y_q <<< 8;
				m_q <= m_q << 8;
			end else if (m_q[CW-1:ptik_pkg::NORM_BIT] == '0) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
				m_q <= m_q << 1;
			end
		end else if (state_q == ptik_pkg::CR_ITER) begin
			if (y_q > 0) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				ang_q <= ang_q + t;
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				ang_q <= ang_q - t;
			end
			i_q <= i_q + 5'd1;
		end
	end

endmodule

// ===== rtl/core/planar_two_link_ik_select.sv =====
// Top level: two-link planar IK with elbow-branch selection, sequenced over shared units.
// Each reachable target takes five atan2 runs in turn on the shared CORDIC unit.
// Input: a new target is taken only in idle, once the previous transaction has ended;
// the last result waits meanwhile.
// Reset: asynchronous, active low; config registers take defaults, stored angles zero.
module planar_two_link_ik_select #(
	parameter int ANGLE_BITS      = ptik_pkg::ANGLE_BITS_DEF,
	parameter int COORD_FRAC_BITS = ptik_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = ptik_pkg::STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ptik_pkg::XY_W-1:0]    target_x,
	input  logic signed [ptik_pkg::XY_W-1:0]    target_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ptik_pkg::ANG16_W-1:0] shoulder_angle,
	output logic signed [ptik_pkg::ANG16_W-1:0] elbow_angle,
	output logic                                reachable,
	output logic                                chose_elbow_down,
	input  logic                                cfg_write,
	input  logic [ptik_pkg::IDX_W-1:0]          cfg_index,
	input  logic [ptik_pkg::CFG_W-1:0]          cfg_data
);

	localparam int F    = COORD_FRAC_BITS;
	localparam int A    = ANGLE_BITS;
	localparam int XW   = ptik_pkg::XY_W;
	localparam int LW   = ptik_pkg::LEN_W;
	localparam int GW   = ptik_pkg::ANG16_W;
	localparam int MW   = ptik_pkg::MAG_W;
	localparam int NW   = ptik_pkg::NUM_W;
	localparam int AW   = (F + 1 > XW) ? F + 1 : XW;
	localparam int BW   = (F + 1 > 20) ? F + 1 : 20;
	localparam int PW   = AW + BW;
	localparam int IW   = (F + 2 > 20) ? F + 2 : 20;
	localparam int DNW  = MW + F + 1;
	localparam int VW   = 2 * F + 1;
	localparam int SH_DN = (A > GW) ? A - GW : 0;
	localparam int SH_UP = (A < GW) ? GW - A : 0;
	localparam logic [BW-1:0]  REACH_SCALE = BW'(1000000);
	localparam logic [F:0]     ONE    = (F+1)'(1) << F;
	localparam logic [VW-1:0]  ONE_SQ = VW'(1) << (2 * F);
	localparam logic [PW-1:0]  HALF_P = PW'(1) << (F - 1);
	localparam logic [A+16:0]  RND    = ((A+17)'(1) << SH_DN) >> 1;

	// Configuration registers.
	logic [LW-1:0]        l1_q, l2_q;
	logic signed [GW-1:0] smin_q, smax_q, emin_q, emax_q;

	// Sequencer and datapath registers.
	ptik_pkg::ik_state_t state_q, state_d;
	ptik_pkg::run_t      run_q;
	logic signed [XW-1:0] x_q, y_q;
	logic [XW-1:0]        ax_q, ay_q;
	logic [PW-1:0]        prod_q;
	logic signed [NW-1:0] acc_q;
	logic [MW-1:0]        mag_q, den_q;
	logic                 neg_q;
	logic [F:0]           cm_q, sm_q;
	logic [XW-1:0]        p_q, q_q;
	logic [A-1:0]         base_q, t2u_q, t2d_q, c1u_q, c1d_q;
	logic [GW-1:0]        spos_q, epos_q;

	// Output register.
	logic                 out_valid_q, reach_q, down_q;
	logic [GW-1:0]        sh_out_q, el_out_q;

	// Combinational signals.
	logic [AW-1:0]        mul_a;
	logic [BW-1:0]        mul_b;
	logic signed [NW-1:0] prod_s;
	logic [MW:0]          diff;
	ptik_pkg::ds_cmd_t    ds_cmd;
	logic [DNW-1:0]       div_num;
	logic [VW-1:0]        sqrt_arg;
	logic                 ds_done, cr_done, cr_start;
	logic [F+1:0]         quotient;
	logic [F:0]           root;
	logic signed [IW-1:0] cr_y, cr_x;
	logic [A-1:0]         cr_angle;
	logic signed [IW-1:0] cv, k1;
	logic signed [GW-1:0] a1u, a2u, a1d, a2d;
	logic [ptik_pkg::COST_W-1:0] cost_u, cost_d;
	logic                 down;
	logic                 out_free;

	// Binary angle of ANGLE_BITS to 16 bits, rounded half up.
	function automatic logic [GW-1:0] to16(input logic [A-1:0] a);
		logic [A+16:0] w;
		w = (A+17)'(a);
		if (A >= GW) w = (w + RND) >> SH_DN;
		else w = w << SH_UP;
		return w[GW-1:0];
	endfunction

	ptik_divsqrt #(.FRAC_BITS(F)) u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ds_cmd),
		.div_num  (div_num),
		.div_den  (den_q),
		.sqrt_arg (sqrt_arg),
		.done     (ds_done),
		.quotient (quotient),
		.root     (root)
	);

	ptik_cordic #(.ANGLE_BITS(A), .STEPS(CORDIC_STEPS), .IW(IW)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cr_start),
		.y_in   (cr_y),
		.x_in   (cr_x),
		.done   (cr_done),
		.angle  (cr_angle)
	);

	// Unit operands and reach-test difference.
	always_comb begin
		prod_s   = $signed({1'b0, prod_q[NW-2:0]});
		diff     = {1'b0, mag_q} - {1'b0, den_q};
		div_num  = {mag_q, {F{1'b0}}, 1'b0} >> 1;
		div_num  = div_num + DNW'(den_q >> 1);
		sqrt_arg = ONE_SQ - prod_q[VW-1:0];
		cv       = neg_q ? -IW'($signed({1'b0, cm_q})) : IW'($signed({1'b0, cm_q}));
		k1       = neg_q ? IW'($signed({1'b0, l1_q})) - IW'($signed({1'b0, p_q}))
		                 : IW'($signed({1'b0, l1_q})) + IW'($signed({1'b0, p_q}));
		out_free = !out_valid_q || !out_stall;
	end

	// atan2 operand selection for the current run.
	always_comb begin
		unique case (run_q)
			ptik_pkg::RUN_BASE: begin
				cr_y = IW'(y_q);
				cr_x = IW'(x_q);
			end
			ptik_pkg::RUN_T2_UP: begin
				cr_y = IW'($signed({1'b0, sm_q}));
				cr_x = cv;
			end
			ptik_pkg::RUN_T2_DN: begin
				cr_y = -IW'($signed({1'b0, sm_q}));
				cr_x = cv;
			end
			ptik_pkg::RUN_C1_UP: begin
				cr_y = IW'($signed({1'b0, q_q}));
				cr_x = k1;
			end
			ptik_pkg::RUN_C1_DN: begin
				cr_y = -IW'($signed({1'b0, q_q}));
				cr_x = k1;
			end
			default: begin
				cr_y = '0;
				cr_x = '0;
			end
		endcase
	end

	// Branch wrap, clamp and cost; the lower cost wins, a tie goes to elbow-up.
	always_comb begin
		a1u    = ptik_pkg::clamp_angle($signed(to16(base_q - c1u_q)), smin_q, smax_q);
		a1d    = ptik_pkg::clamp_angle($signed(to16(base_q - c1d_q)), smin_q, smax_q);
		a2u    = ptik_pkg::clamp_angle($signed(to16(t2u_q)), emin_q, emax_q);
		a2d    = ptik_pkg::clamp_angle($signed(to16(t2d_q)), emin_q, emax_q);
		cost_u = ptik_pkg::COST_W'(ptik_pkg::wrap_dist(a1u, spos_q))
		       + ptik_pkg::COST_W'(ptik_pkg::wrap_dist(a2u, epos_q));
		cost_d = ptik_pkg::COST_W'(ptik_pkg::wrap_dist(a1d, spos_q))
		       + ptik_pkg::COST_W'(ptik_pkg::wrap_dist(a2d, epos_q));
		down   = cost_d < cost_u;
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptik_pkg::ST_IDLE: if (in_valid) state_d = ptik_pkg::ST_XX;
			ptik_pkg::ST_XX:   state_d = ptik_pkg::ST_YY;
			ptik_pkg::ST_YY:   state_d = ptik_pkg::ST_L1;
			ptik_pkg::ST_L1:   state_d = ptik_pkg::ST_L2;
			ptik_pkg::ST_L2:   state_d = ptik_pkg::ST_LL;
			ptik_pkg::ST_LL:   state_d = ptik_pkg::ST_DEN;
			ptik_pkg::ST_DEN:  state_d = ptik_pkg::ST_CHK1;
			ptik_pkg::ST_CHK1: begin
				priority if (den_q == '0) state_d = ptik_pkg::ST_UNR;
				else if (mag_q <= den_q) state_d = ptik_pkg::ST_DIV;
				else if (diff[MW-1:17] != '0) state_d = ptik_pkg::ST_UNR;
				else state_d = ptik_pkg::ST_CHK2;
			end
			ptik_pkg::ST_CHK2: begin
				state_d = (prod_q <= PW'(den_q)) ? ptik_pkg::ST_DIV : ptik_pkg::ST_UNR;
			end
			ptik_pkg::ST_DIV:  state_d = ptik_pkg::ST_DIVW;
			ptik_pkg::ST_DIVW: if (ds_done) state_d = ptik_pkg::ST_CM2;
			ptik_pkg::ST_CM2:  state_d = ptik_pkg::ST_SQ;
			ptik_pkg::ST_SQ:   state_d = ptik_pkg::ST_SQW;
			ptik_pkg::ST_SQW:  if (ds_done) state_d = ptik_pkg::ST_P;
			ptik_pkg::ST_P:    state_d = ptik_pkg::ST_Q;
			ptik_pkg::ST_Q:    state_d = ptik_pkg::ST_QR;
			ptik_pkg::ST_QR:   state_d = ptik_pkg::ST_COR;
			ptik_pkg::ST_COR:  state_d = ptik_pkg::ST_CORW;
			ptik_pkg::ST_CORW: begin
				if (cr_done) begin
					state_d = (run_q == ptik_pkg::RUN_C1_DN) ? ptik_pkg::ST_SEL
					                                        : ptik_pkg::ST_COR;
				end
			end
			ptik_pkg::ST_SEL, ptik_pkg::ST_UNR: if (out_free) state_d = ptik_pkg::ST_IDLE;
			default: state_d = ptik_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands and unit starts.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		ds_cmd    = '0;
		cr_start  = 1'b0;
		in_stall  = (state_q != ptik_pkg::ST_IDLE);
		unique case (state_q)
			ptik_pkg::ST_XX: begin
				mul_a = AW'(ax_q);
				mul_b = BW'(ax_q);
			end
			ptik_pkg::ST_YY: begin
				mul_a = AW'(ay_q);
				mul_b = BW'(ay_q);
			end
			ptik_pkg::ST_L1: begin
				mul_a = AW'(l1_q);
				mul_b = BW'(l1_q);
			end
			ptik_pkg::ST_L2: begin
				mul_a = AW'(l2_q);
				mul_b = BW'(l2_q);
			end
			ptik_pkg::ST_LL: begin
				mul_a = AW'(l1_q);
				mul_b = BW'(l2_q);
			end
			ptik_pkg::ST_CHK1: begin
				mul_a = AW'(diff[16:0]);
				mul_b = REACH_SCALE;
			end
			ptik_pkg::ST_DIV: begin
				ds_cmd.start = 1'b1;
			end
			ptik_pkg::ST_CM2: begin
				mul_a = AW'(cm_q);
				mul_b = BW'(cm_q);
			end
			ptik_pkg::ST_SQ: begin
				ds_cmd.start     = 1'b1;
				ds_cmd.sqrt_mode = 1'b1;
			end
			ptik_pkg::ST_P: begin
				mul_a = AW'(l2_q);
				mul_b = BW'(cm_q);
			end
			ptik_pkg::ST_Q: begin
				mul_a = AW'(l2_q);
				mul_b = BW'(sm_q);
			end
			ptik_pkg::ST_COR: begin
				cr_start = 1'b1;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Control state: sequencer, run counter, stored angles, output handshake, configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptik_pkg::ST_IDLE;
			run_q       <= ptik_pkg::RUN_BASE;
			spos_q      <= '0;
			epos_q      <= '0;
			out_valid_q <= 1'b0;
			l1_q        <= LW'(11469);
			l2_q        <= LW'(6554);
			smin_q      <= 16'sh8000;
			smax_q      <= 16'sh7FFF;
			emin_q      <= 16'sh8000;
			emax_q      <= 16'sh7FFF;
		end else begin
			state_q <= state_d;
			if (state_q == ptik_pkg::ST_QR) begin
				run_q <= ptik_pkg::RUN_BASE;
			end else if (state_q == ptik_pkg::ST_CORW && cr_done) begin
				run_q <= ptik_pkg::run_t'(run_q + 3'd1);
			end
			if (state_q == ptik_pkg::ST_SEL && out_free) begin
				spos_q <= down ? a1d : a1u;
				epos_q <= down ? a2d : a2u;
			end
			if ((state_q == ptik_pkg::ST_SEL || state_q == ptik_pkg::ST_UNR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					ptik_pkg::REG_UPPER_LEN: l1_q   <= cfg_data;
					ptik_pkg::REG_LOWER_LEN: l2_q   <= cfg_data;
					ptik_pkg::REG_SHLDR_MIN: smin_q <= $signed(cfg_data[GW-1:0]);
					ptik_pkg::REG_SHLDR_MAX: smax_q <= $signed(cfg_data[GW-1:0]);
					ptik_pkg::REG_ELBOW_MIN: emin_q <= $signed(cfg_data[GW-1:0]);
					ptik_pkg::REG_ELBOW_MAX: emax_q <= $signed(cfg_data[GW-1:0]);
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ptik_pkg::ST_IDLE: begin
				x_q  <= target_x;
				y_q  <= target_y;
				ax_q <= target_x[XW-1] ? XW'(-target_x) : XW'(target_x);
				ay_q <= target_y[XW-1] ? XW'(-target_y) : XW'(target_y);
			end
			ptik_pkg::ST_YY: acc_q <= prod_s;
			ptik_pkg::ST_L1: acc_q <= acc_q + prod_s;
			ptik_pkg::ST_L2: acc_q <= acc_q - prod_s;
			ptik_pkg::ST_LL: acc_q <= acc_q - prod_s;
			ptik_pkg::ST_DEN: begin
				den_q <= {prod_q[MW-2:0], 1'b0};
				mag_q <= acc_q[NW-1] ? MW'(-acc_q) : MW'(acc_q);
				neg_q <= acc_q[NW-1];
			end
			ptik_pkg::ST_DIVW: begin
				if (ds_done) cm_q <= (quotient > {1'b0, ONE}) ? ONE : quotient[F:0];
			end
			ptik_pkg::ST_SQW: begin
				if (ds_done) sm_q <= root;
			end
			ptik_pkg::ST_Q:  p_q <= XW'((prod_q + HALF_P) >> F);
			ptik_pkg::ST_QR: q_q <= XW'((prod_q + HALF_P) >> F);
			ptik_pkg::ST_CORW: begin
				if (cr_done) begin
					unique case (run_q)
						ptik_pkg::RUN_BASE:  base_q <= cr_angle;
						ptik_pkg::RUN_T2_UP: t2u_q  <= cr_angle;
						ptik_pkg::RUN_T2_DN: t2d_q  <= cr_angle;
						ptik_pkg::RUN_C1_UP: c1u_q  <= cr_angle;
						ptik_pkg::RUN_C1_DN: c1d_q  <= cr_angle;
						default: ;
					endcase
				end
			end
			ptik_pkg::ST_SEL: begin
				if (out_free) begin
					sh_out_q <= down ? a1d : a1u;
					el_out_q <= down ? a2d : a2u;
					reach_q  <= 1'b1;
					down_q   <= down;
				end
			end
			ptik_pkg::ST_UNR: begin
				if (out_free) begin
					sh_out_q <= spos_q;
					el_out_q <= epos_q;
					reach_q  <= 1'b0;
					down_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign shoulder_angle   = $signed(sh_out_q);
	assign elbow_angle      = $signed(el_out_q);
	assign reachable        = reach_q;
	assign chose_elbow_down = down_q;

	// A new result appears only out of the final selection states.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ptik_pkg::ST_SEL || state_q == ptik_pkg::ST_UNR))
		else $error("result raised outside the selection states");

	// An unreachable result never reports the elbow-down branch.
	a_unreach_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !reach_q) |-> !down_q)
		else $error("unreachable result flags elbow-down");

	// A pending result always shows the stored joint angles.
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sh_out_q == spos_q && el_out_q == epos_q))
		else $error("pending result differs from stored angles");

endmodule
